// ===== sv/rkd_pkg.sv =====
// Package of shared types, constants and widths for the rotary knob decoder.
package rkd_pkg;

    localparam int PRESS_COUNT_WIDTH  = 16;
    localparam int FILTER_COUNT_WIDTH = 8;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CHANGE_W    = 8;

    // Widths wide enough for both sides of each threshold compare.
    localparam int FILT_CMP_W  = (FILTER_COUNT_WIDTH > 8) ? FILTER_COUNT_WIDTH : 8;
    localparam int PRESS_CMP_W = (PRESS_COUNT_WIDTH > 16) ? PRESS_COUNT_WIDTH : 16;

    typedef logic [FILTER_COUNT_WIDTH-1:0] filt_count_t;
    typedef logic [PRESS_COUNT_WIDTH-1:0]  press_count_t;
    typedef logic [CHANGE_W-1:0]           change_count_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_TICKS       = 2'd0,
        CFG_SWITCH_CONFIRM_TICKS = 2'd1,
        CFG_MIN_PRESS_TICKS      = 2'd2,
        CFG_LONG_PRESS_TICKS     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [7:0]  switch_confirm_ticks;
        logic [15:0] min_press_ticks;
        logic [15:0] long_press_ticks;
    } cfg_t;

    localparam logic [7:0]  DEBOUNCE_TICKS_RST       = 8'd3;
    localparam logic [7:0]  SWITCH_CONFIRM_TICKS_RST = 8'd10;
    localparam logic [15:0] MIN_PRESS_TICKS_RST      = 16'd50;
    localparam logic [15:0] LONG_PRESS_TICKS_RST     = 16'd600;

    typedef struct packed {
        logic a;
        logic b;
        logic sw;
    } levels_t;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_A_FIRST      = 3'd1,
        PH_B_FIRST      = 3'd2,
        PH_BOTH_AFTER_A = 3'd3,
        PH_BOTH_AFTER_B = 3'd4
    } rot_phase_t;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } rot_event_t;

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_SHORT  = 2'd1,
        BTN_LONG   = 2'd2,
        BTN_REJECT = 2'd3
    } btn_event_t;

endpackage

// ===== sv/rkd_debounce.sv =====
// Stable-count debounce filter for one input line.
module rkd_debounce (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       raw,
    input  logic [7:0] debounce_ticks,
    output logic       level_next
);

    logic                 filt_reg, filt_next;
    logic                 last_reg, last_next;
    rkd_pkg::filt_count_t cnt_reg, cnt_next;

    always_comb
    begin
        filt_next = filt_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        if (raw == last_reg)
        begin
            if (cnt_reg != '1)
            begin
                cnt_next = cnt_reg + rkd_pkg::filt_count_t'(1);
            end
            if (rkd_pkg::FILT_CMP_W'(cnt_next) >= rkd_pkg::FILT_CMP_W'(debounce_ticks))
            begin
                filt_next = raw;
            end
        end
        else
        begin
            cnt_next  = '0;
            last_next = raw;
        end
    end

    // The level after this tick is what the rest of the tick works on.
    assign level_next = tick ? filt_next : filt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= 1'b1;
            last_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (tick)
        begin
            filt_reg <= filt_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/rkd_rotation.sv =====
// Five-phase rotation step machine working on the debounced phase levels.
module rkd_rotation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  rkd_pkg::levels_t    levels,
    output rkd_pkg::rot_event_t rot_event
);

    rkd_pkg::rot_phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rkd_pkg::PH_IDLE;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rot_event  = rkd_pkg::ROT_NONE;
        if (levels.a && levels.b)
        begin
            if (phase_reg == rkd_pkg::PH_BOTH_AFTER_A)
            begin
                rot_event = rkd_pkg::ROT_CW;
            end
            else if (phase_reg == rkd_pkg::PH_BOTH_AFTER_B)
            begin
                rot_event = rkd_pkg::ROT_CCW;
            end
            phase_next = rkd_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                rkd_pkg::PH_IDLE:
                begin
                    if (!levels.a && levels.b)
                    begin
                        phase_next = rkd_pkg::PH_A_FIRST;
                    end
                    else if (!levels.b && levels.a)
                    begin
                        phase_next = rkd_pkg::PH_B_FIRST;
                    end
                end
                rkd_pkg::PH_A_FIRST:
                begin
                    if (!levels.a && !levels.b)
                    begin
                        phase_next = rkd_pkg::PH_BOTH_AFTER_A;
                    end
                end
                rkd_pkg::PH_B_FIRST:
                begin
                    if (!levels.a && !levels.b)
                    begin
                        phase_next = rkd_pkg::PH_BOTH_AFTER_B;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule

// ===== sv/rkd_switch.sv =====
// Push switch confirmation, press timing and press classification.
module rkd_switch (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick,
    input  rkd_pkg::levels_t    levels,
    input  rkd_pkg::cfg_t       cfg,
    output rkd_pkg::btn_event_t btn_event
);

    logic                   accepted_reg, accepted_next;
    rkd_pkg::change_count_t change_reg, change_next;
    logic                   active_reg, active_next;
    rkd_pkg::press_count_t  ticks_reg, ticks_next;
    logic                   bfell_reg, bfell_next;

    rkd_pkg::press_count_t  ticks_run;
    rkd_pkg::change_count_t change_inc;
    logic                   bfell_run;

    always_comb
    begin
        ticks_run = ticks_reg;
        if (active_reg && (ticks_reg != '1))
        begin
            ticks_run = ticks_reg + rkd_pkg::press_count_t'(1);
        end
        bfell_run  = bfell_reg | (active_reg & ~levels.b);
        change_inc = change_reg;
        if (change_reg != '1)
        begin
            change_inc = change_reg + rkd_pkg::change_count_t'(1);
        end

        accepted_next = accepted_reg;
        change_next   = '0;
        active_next   = active_reg;
        ticks_next    = ticks_run;
        bfell_next    = bfell_run;
        btn_event     = rkd_pkg::BTN_NONE;

        if (levels.sw != accepted_reg)
        begin
            change_next = change_inc;
            if (change_inc > rkd_pkg::change_count_t'(cfg.switch_confirm_ticks))
            begin
                if (!levels.sw)
                begin
                    active_next = 1'b1;
                    ticks_next  = '0;
                    bfell_next  = ~levels.b;
                end
                else
                begin
                    if (active_reg && (rkd_pkg::PRESS_CMP_W'(ticks_run) >
                                       rkd_pkg::PRESS_CMP_W'(cfg.min_press_ticks)))
                    begin
                        if (bfell_run)
                        begin
                            btn_event = rkd_pkg::BTN_REJECT;
                        end
                        else if (rkd_pkg::PRESS_CMP_W'(ticks_run) >=
                                 rkd_pkg::PRESS_CMP_W'(cfg.long_press_ticks))
                        begin
                            btn_event = rkd_pkg::BTN_LONG;
                        end
                        else
                        begin
                            btn_event = rkd_pkg::BTN_SHORT;
                        end
                    end
                    active_next = 1'b0;
                    ticks_next  = '0;
                end
                accepted_next = levels.sw;
                change_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= 1'b1;
            change_reg   <= '0;
            active_reg   <= 1'b0;
            ticks_reg    <= '0;
            bfell_reg    <= 1'b0;
        end
        else if (tick)
        begin
            accepted_reg <= accepted_next;
            change_reg   <= change_next;
            active_reg   <= active_next;
            ticks_reg    <= ticks_next;
            bfell_reg    <= bfell_next;
        end
    end

endmodule

// ===== sv/rotary_knob_decoder.sv =====
// Top level of the rotary knob decoder: debounce, rotation machine, switch and result register.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    raw_a, raw_b, raw_switch
//  result    out        out_valid / out_stall  rotation_event, button_event, level_a,
//                                              level_b, level_switch
//  config    in         cfg_we                 cfg_index, cfg_data
//
// Each accepted item is one poll tick and yields exactly one result item. The tick's
// work is done in the cycle it is accepted and the result appears in the result
// register on the next cycle, so one item per cycle is sustained while the result
// is not stalled. The state registers of the filters, the rotation machine and the switch
// logic are updated at the same edge. The result register holds one item: while it
// is full and stalled, in_stall is raised; it is raised in no other case.
// Reset is asynchronous and active low; it restores the state and configuration
// registers to their reset values and empties the result register.
module rotary_knob_decoder (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            raw_a,
    input  logic                            raw_b,
    input  logic                            raw_switch,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      rotation_event,
    output logic [1:0]                      button_event,
    output logic                            level_a,
    output logic                            level_b,
    output logic                            level_switch,

    input  logic                            cfg_we,
    input  logic [rkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rkd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rkd_pkg::cfg_t       cfg_reg;
    rkd_pkg::levels_t    levels;
    rkd_pkg::rot_event_t rot_event;
    rkd_pkg::btn_event_t btn_event;
    logic                tick;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] rot_reg, btn_reg;
    logic       la_reg, lb_reg, lsw_reg;

    // The result register can take a new item unless it holds one that is stalled.
    assign in_stall = out_valid_reg & out_stall;
    assign tick     = in_valid & ~in_stall;

    // Configuration registers: written directly, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks       <= rkd_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.switch_confirm_ticks <= rkd_pkg::SWITCH_CONFIRM_TICKS_RST;
            cfg_reg.min_press_ticks      <= rkd_pkg::MIN_PRESS_TICKS_RST;
            cfg_reg.long_press_ticks     <= rkd_pkg::LONG_PRESS_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (rkd_pkg::cfg_index_t'(cfg_index))
                rkd_pkg::CFG_DEBOUNCE_TICKS:
                begin
                    cfg_reg.debounce_ticks <= cfg_data[7:0];
                end
                rkd_pkg::CFG_SWITCH_CONFIRM_TICKS:
                begin
                    cfg_reg.switch_confirm_ticks <= cfg_data[7:0];
                end
                rkd_pkg::CFG_MIN_PRESS_TICKS:
                begin
                    cfg_reg.min_press_ticks <= cfg_data[15:0];
                end
                rkd_pkg::CFG_LONG_PRESS_TICKS:
                begin
                    cfg_reg.long_press_ticks <= cfg_data[15:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // One debounce filter per line; their outputs are the levels after this tick.
    rkd_debounce u_deb_a (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .raw            (raw_a),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .level_next     (levels.a)
    );

    rkd_debounce u_deb_b (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .raw            (raw_b),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .level_next     (levels.b)
    );

    rkd_debounce u_deb_sw (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .raw            (raw_switch),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .level_next     (levels.sw)
    );

    rkd_rotation u_rotation (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .levels    (levels),
        .rot_event (rot_event)
    );

    rkd_switch u_switch (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .levels    (levels),
        .cfg       (cfg_reg),
        .btn_event (btn_event)
    );

    // Result register: fills on a tick, empties when the item is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; it is only looked at while out_valid is high.
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            rot_reg <= rot_event;
            btn_reg <= btn_event;
            la_reg  <= levels.a;
            lb_reg  <= levels.b;
            lsw_reg <= levels.sw;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rotation_event = rot_reg;
    assign button_event   = btn_reg;
    assign level_a        = la_reg;
    assign level_b        = lb_reg;
    assign level_switch   = lsw_reg;

endmodule

// ===== sv/rkd_checker.sv =====
// Port-level assertion checker for the rotary knob decoder, with its bind statement.
module rkd_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] rotation_event,
    input logic [1:0] button_event,
    input logic       level_a,
    input logic       level_b,
    input logic       level_switch
);

    logic in_take;
    logic out_hold;

    assign in_take  = in_valid & ~in_stall;
    assign out_hold = out_valid & out_stall;

    // The input side is held off only while a finished result is stalled.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == out_hold)
        else $error("in_stall does not follow a stalled full result register");

    // Every accepted item gives a result item on the next cycle.
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> out_valid)
        else $error("accepted item produced no result");

    // No result appears without an item behind it.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_take && !out_hold) |=> !out_valid)
        else $error("result appeared without an accepted item");

    // A stalled result stays offered.
    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_hold |=> out_valid && $stable(rotation_event) && $stable(button_event) &&
                     $stable(level_a) && $stable(level_b) && $stable(level_switch))
        else $error("stalled result changed or vanished");

    // A step is reported only when both phases are back high.
    a_step_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (rotation_event != rkd_pkg::ROT_NONE)) |-> (level_a && level_b))
        else $error("rotation step reported while a phase is low");

endmodule

bind rotary_knob_decoder rkd_port_checker u_rkd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rotation_event (rotation_event),
    .button_event   (button_event),
    .level_a        (level_a),
    .level_b        (level_b),
    .level_switch   (level_switch)
);
